/* rtl/core/lfw_pkg.sv */
package lfw_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic [7:0] MAX_LINE_RESET = 8'd79;

  localparam int         COL_W       = 9;
  localparam int         COL_MAX_INT = 511;
  localparam logic [COL_W-1:0] COL_MAX = 9'd511;

  localparam int WORD_DEPTH_DEF = 32;
  localparam int TAB_STOP_DEF   = 8;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } lfw_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_of_run;
  } lfw_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BREAK,
    S_FLUSH,
    S_BLANK
  } lfw_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_in;   // latch request, rewind read index
    logic store;     // append request byte to the word
    logic brk;       // emit line break before the word
    logic flush;     // emit one word byte
    logic blank;     // emit the blank (or its newline)
  } lfw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_blank;
    logic in_eoi;
    logic word_empty;
    logic word_full;
    logic blank_r;
    logic need_break;
    logic flush_last;
    logic slot_free;
  } lfw_status_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

endpackage

/* rtl/core/lfw_ctrl.sv */
module lfw_ctrl
  import lfw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  lfw_status_t st,
  output lfw_cmd_t    cmd
);

  lfw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (st.in_eoi) begin
            state_nxt = st.word_empty ? S_IDLE : S_FLUSH;
          end else if (st.in_blank) begin
            state_nxt = st.word_empty ? S_BLANK : S_BREAK;
          end else if (st.word_full) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_BREAK: begin
        if (!st.need_break || st.slot_free) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (st.slot_free && st.flush_last) begin
          state_nxt = st.blank_r ? S_BLANK : S_IDLE;
        end
      end
      S_BLANK: begin
        if (st.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.take_in = in_valid;
        cmd.store   = in_valid && !st.in_eoi && !st.in_blank && !st.word_full;
      end
      S_BREAK: cmd.brk   = st.need_break && st.slot_free;
      S_FLUSH: cmd.flush = st.slot_free;
      S_BLANK: cmd.blank = st.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/lfw_datapath.sv */
module lfw_datapath
  import lfw_pkg::*;
#(
  parameter int WORD_DEPTH = WORD_DEPTH_DEF,
  parameter int TAB_STOP   = TAB_STOP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lfw_in_t     in_data,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  lfw_cmd_t    cmd,
  output lfw_status_t st,
  output logic        out_valid,
  input  logic        out_stall,
  output lfw_out_t    out_data
);

  localparam int CNT_W = $clog2(WORD_DEPTH);
  localparam int PH_W  = $clog2(TAB_STOP + 1);
  localparam logic [PH_W-1:0]  SAT_PHASE = PH_W'(COL_MAX_INT % TAB_STOP);
  localparam logic [PH_W-1:0]  TAB_LAST  = PH_W'(TAB_STOP - 1);
  localparam logic [PH_W-1:0]  TAB_W     = PH_W'(TAB_STOP);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WORD_DEPTH - 1);

  logic [7:0]       max_line_r, max_line_nxt;
  logic [COL_W-1:0] column_r, column_nxt;
  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic             may_break_r, may_break_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             eoi_r, eoi_nxt;
  logic             out_valid_r, out_valid_nxt;
  lfw_out_t         out_data_r, out_data_nxt;

  logic [7:0]       mem [WORD_DEPTH];
  logic [7:0]       rd_data_r;
  logic             wr_en;
  logic [CNT_W-1:0] wr_addr;
  logic [7:0]       wr_data;

  logic             slot_free;
  logic             blank_r;
  logic             is_tab;
  logic [PH_W-1:0]  blank_w;
  logic [COL_W:0]   sum_word;
  logic [COL_W:0]   sum_blank;
  logic             blank_nl;
  logic             blank_sat;
  logic             flush_last;
  logic [PH_W-1:0]  phase_inc;

  assign slot_free  = !out_valid_r || !out_stall;
  assign blank_r    = !eoi_r && is_blank(char_r);
  assign is_tab     = (char_r == CH_TAB);
  assign blank_w    = is_tab ? (TAB_W - phase_r) : PH_W'(1);
  assign sum_word   = {1'b0, column_r} + (COL_W+1)'(count_r);
  assign sum_blank  = {1'b0, column_r} + (COL_W+1)'(blank_w);
  assign blank_nl   = (char_r == CH_NL) || (sum_blank > (COL_W+1)'(max_line_r));
  assign blank_sat  = sum_blank > (COL_W+1)'(COL_MAX);
  assign flush_last = (idx_r == count_r - CNT_W'(1));
  assign phase_inc  = (phase_r == TAB_LAST) ? '0 : phase_r + PH_W'(1);

  always_comb begin
    st.in_blank   = is_blank(in_data.char_in);
    st.in_eoi     = in_data.end_of_input;
    st.word_empty = (count_r == '0);
    st.word_full  = (count_r == FULL_CNT);
    st.blank_r    = blank_r;
    st.need_break = may_break_r && (sum_word > (COL_W+1)'(max_line_r));
    st.flush_last = flush_last;
    st.slot_free  = slot_free;
  end

  always_comb begin
    max_line_nxt  = cfg_wr_en ? cfg_wr_data : max_line_r;
    column_nxt    = column_r;
    phase_nxt     = phase_r;
    may_break_nxt = may_break_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    char_nxt      = char_r;
    eoi_nxt       = eoi_r;
    wr_en         = 1'b0;
    wr_addr       = count_r;
    wr_data       = in_data.char_in;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cmd.take_in) begin
      char_nxt = in_data.char_in;
      eoi_nxt  = in_data.end_of_input;
      idx_nxt  = '0;
    end

    if (cmd.store) begin
      wr_en     = 1'b1;
      count_nxt = count_r + CNT_W'(1);
    end

    if (cmd.brk) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{char_out: CH_NL, last_of_run: 1'b0};
      column_nxt    = '0;
      phase_nxt     = '0;
      may_break_nxt = 1'b0;
    end

    if (cmd.flush) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{char_out: rd_data_r, last_of_run: flush_last && !blank_r};
      if (column_r != COL_MAX) begin
        column_nxt = column_r + COL_W'(1);
        phase_nxt  = phase_inc;
      end
      idx_nxt = idx_r + CNT_W'(1);
      if (flush_last) begin
        idx_nxt = '0;
        if (!eoi_r && !blank_r) begin
          // full word: the request byte starts the next word
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = char_r;
          count_nxt = CNT_W'(1);
        end else begin
          count_nxt = '0;
        end
      end
    end

    if (cmd.blank) begin
      out_valid_nxt = 1'b1;
      if (blank_nl) begin
        out_data_nxt  = '{char_out: CH_NL, last_of_run: 1'b1};
        column_nxt    = '0;
        phase_nxt     = '0;
        may_break_nxt = 1'b0;
      end else begin
        out_data_nxt  = '{char_out: char_r, last_of_run: 1'b1};
        may_break_nxt = 1'b1;
        if (blank_sat) begin
          column_nxt = COL_MAX;
          phase_nxt  = SAT_PHASE;
        end else begin
          column_nxt = sum_blank[COL_W-1:0];
          phase_nxt  = is_tab ? '0 : phase_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r  <= MAX_LINE_RESET;
      column_r    <= '0;
      phase_r     <= '0;
      may_break_r <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      max_line_r  <= max_line_nxt;
      column_r    <= column_nxt;
      phase_r     <= phase_nxt;
      may_break_r <= may_break_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    eoi_r      <= eoi_nxt;
    out_data_r <= out_data_nxt;
  end

  // word buffer; read port follows the next index so data lines up with idx_r
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[idx_nxt];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/line_fold_word_wrap.sv */
// channel | direction | handshake          | payload
// in      | input     | in_valid / in_stall   | lfw_in_t  (char_in, end_of_input)
// out     | output    | out_valid / out_stall | lfw_out_t (char_out, last_of_run)
// cfg     | input     | cfg_wr_en             | cfg_wr_data = max_line
//
// A non-blank byte is appended to the word without leaving idle. A blank runs a break
// check that emits the break if one is due, then the word's bytes, then the blank
// (just the blank with an empty word). An end-of-input or a byte meeting a full word
// emits only the word; the single read port gives one byte a cycle unless stalled.
// Reset is synchronous on rst_n; max_line returns to 79, the line and word are empty.
// out_stall holds the output register and the emitting step; in_stall is high while
// a request is being worked.
module line_fold_word_wrap
  import lfw_pkg::*;
#(
  parameter int WORD_DEPTH = WORD_DEPTH_DEF,
  parameter int TAB_STOP   = TAB_STOP_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  lfw_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output lfw_out_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  lfw_cmd_t    cmd;
  lfw_status_t st;

  lfw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  lfw_datapath #(
    .WORD_DEPTH (WORD_DEPTH),
    .TAB_STOP   (TAB_STOP)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.store, cmd.brk, cmd.flush, cmd.blank}))
    else $error("more than one datapath command at once");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.brk || cmd.flush || cmd.blank) |-> st.slot_free)
    else $error("emit while output register is held");

  a_blank_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.blank |=> !in_stall)
    else $error("not back to idle after the blank");

endmodule

/* tb/tb_line_fold_word_wrap.sv */
module tb_line_fold_word_wrap;
  timeunit 1ns;
  timeprecision 1ps;

  import lfw_pkg::*;

  localparam int HANG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;

  // how a directed row is checked
  typedef enum logic [1:0] {
    LIT_PRED,
    LIT_NONE,
    LIT_ONE
  } lit_e;

  typedef struct packed {
    logic       is_cfg;
    logic       eoi;
    logic [7:0] val;
    logic [9:0] rep;
    lit_e       lit;
    logic [7:0] lit_ch;
  } step_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  lfw_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  lfw_out_t   out_data;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  int send_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  // predictor state
  logic [7:0]  line_limit = MAX_LINE_RESET;
  logic [8:0]  col = '0;
  logic [7:0]  word_buf [WORD_DEPTH_DEF];
  int unsigned word_len = 0;
  bit          blank_seen = 1'b0;

  lfw_out_t folded_now [$];
  lfw_out_t folded_due [$];
  step_row_t plan [$];

  line_fold_word_wrap dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic void emit_char(logic [7:0] c);
    lfw_out_t r;
    r.char_out = c;
    r.last_of_run = 1'b0;
    folded_now.push_back(r);
  endfunction

  function automatic void advance_col(int unsigned w);
    int unsigned s;
    s = int'(col) + w;
    col = (s > COL_MAX_INT) ? COL_MAX : s[8:0];
  endfunction

  function automatic void flush_word();
    for (int k = 0; k < word_len; k++) emit_char(word_buf[k]);
    advance_col(word_len);
    word_len = 0;
  endfunction

  function automatic void fold_byte(lfw_in_t req);
    int unsigned w;
    logic [7:0] c;
    c = req.char_in;
    folded_now.delete();
    if (req.end_of_input) begin
      flush_word();
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
      if (word_len != 0) begin
        if (blank_seen && int'(col) + word_len > int'(line_limit)) begin
          emit_char(CH_NL);
          col = '0;
          blank_seen = 1'b0;
        end
        flush_word();
      end
      w = (c == CH_TAB) ? TAB_STOP_DEF - (int'(col) % TAB_STOP_DEF) : 1;
      if (c == CH_NL || int'(col) + w > int'(line_limit)) begin
        emit_char(CH_NL);
        col = '0;
        blank_seen = 1'b0;
      end else begin
        emit_char(c);
        advance_col(w);
        blank_seen = 1'b1;
      end
    end else begin
      // full word: flush unbroken, keep this byte as the next word's first
      if (word_len >= WORD_DEPTH_DEF - 1) flush_word();
      word_buf[word_len] = c;
      word_len++;
    end
    if (folded_now.size() != 0) folded_now[$].last_of_run = 1'b1;
  endfunction

  task automatic send_req(input lfw_in_t req, input lit_e lit, input logic [7:0] lit_ch);
    lfw_out_t r;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_byte(req);
    case (lit)
      LIT_PRED: foreach (folded_now[i]) folded_due.push_back(folded_now[i]);
      LIT_ONE: begin
        r.char_out = lit_ch;
        r.last_of_run = 1'b1;
        folded_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  // hold off the sender until the block has caught up
  task automatic drain_results();
    in_valid <= 1'b0;
    while (folded_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_limit(input logic [7:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    line_limit = v;
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_NL);
    return c;
  endfunction

  // mostly words and blanks, with stray bytes and end-of-input requests mixed in
  task automatic random_text(input int n_items);
    int sent;
    int pick;
    int len;
    logic [7:0] blank;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if ($urandom_range(59) == 0) drain_results();
      if (pick < 6) begin
        send_req({8'($urandom_range(255)), 1'b1}, LIT_PRED, 8'h00);
        sent++;
      end else if (pick < 12) begin
        send_req({8'($urandom_range(255)), 1'b0}, LIT_PRED, 8'h00);
        sent++;
      end else begin
        len = ($urandom_range(19) == 0) ? $urandom_range(32, 70) : $urandom_range(1, 12);
        repeat (len) send_req({word_char(), 1'b0}, LIT_PRED, 8'h00);
        pick = $urandom_range(9);
        blank = (pick < 7) ? CH_SPACE : (pick < 9) ? CH_TAB : CH_NL;
        send_req({blank, 1'b0}, LIT_PRED, 8'h00);
        sent += len + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    lfw_out_t want;
    if (out_valid && !out_stall) begin
      if (folded_due.size() == 0) begin
        $display("%0t: unexpected byte %02h last %0b", $time, out_data.char_out,
                 out_data.last_of_run);
        errors++;
      end else begin
        want = folded_due.pop_front();
        if (out_data.char_out !== want.char_out) begin
          $display("%0t: char_out expected %02h got %02h", $time, want.char_out,
                   out_data.char_out);
          errors++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %0b got %0b", $time, want.last_of_run,
                   out_data.last_of_run);
          errors++;
        end
      end
    end
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("[line_fold_word_wrap] ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0] lim;
    // limit 79 from reset
    plan.push_back('{1'b0, 1'b0, CH_NL, 10'd1, LIT_ONE, CH_NL});
    plan.push_back('{1'b0, 1'b1, 8'h00, 10'd1, LIT_NONE, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_SPACE, 10'd1, LIT_ONE, CH_SPACE});
    plan.push_back('{1'b0, 1'b0, 8'hFF, 10'd1, LIT_NONE, 8'h00});
    plan.push_back('{1'b0, 1'b0, 8'h00, 10'd1, LIT_NONE, 8'h00});
    plan.push_back('{1'b0, 1'b1, 8'hA5, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_TAB, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, "a", 10'd35, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_SPACE, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, "b", 10'd36, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_TAB, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, "c", 10'd10, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_NL, 10'd1, LIT_PRED, 8'h00});
    // zero limit: every space and tab folds
    plan.push_back('{1'b1, 1'b0, 8'd0, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_SPACE, 10'd1, LIT_ONE, CH_NL});
    plan.push_back('{1'b0, 1'b0, CH_TAB, 10'd1, LIT_ONE, CH_NL});
    plan.push_back('{1'b0, 1'b0, "d", 10'd3, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_SPACE, 10'd1, LIT_PRED, 8'h00});
    // widest limit
    plan.push_back('{1'b1, 1'b0, 8'd255, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, "e", 10'd4, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_TAB, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b1, 1'b0, 8'd8, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, "f", 10'd5, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_SPACE, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, "g", 10'd4, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_SPACE, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, "h", 10'd2, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_TAB, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b1, 1'b0, 8'd3, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, "i", 10'd2, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_SPACE, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b0, CH_TAB, 10'd1, LIT_PRED, 8'h00});
    plan.push_back('{1'b0, 1'b1, 8'h00, 10'd1, LIT_PRED, 8'h00});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        set_line_limit(plan[i].val);
      else
        repeat (plan[i].rep) send_req({plan[i].val, plan[i].eoi}, plan[i].lit,
                                      plan[i].lit_ch);
    end

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin lim = 8'd8; send_pct = 0; stall_pct = 0; end
        1: begin lim = 8'd255; send_pct = 67; stall_pct = 0; end
        2: begin lim = 8'($urandom_range(8, 255)); send_pct = 0; stall_pct = 67; end
        3: begin lim = 8'($urandom_range(0, 7)); send_pct = 27; stall_pct = 27; end
        default: begin lim = MAX_LINE_RESET; send_pct = 0; stall_pct = 0; end
      endcase
      set_line_limit(lim);
      random_text(15);
    end

    in_valid <= 1'b0;
    while (folded_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[line_fold_word_wrap] OK");
    else
      $display("[line_fold_word_wrap] ERROR");
    $finish;
  end

endmodule

/* line_fold_word_wrap.f */
rtl/core/lfw_pkg.sv
rtl/core/lfw_ctrl.sv
rtl/core/lfw_datapath.sv
rtl/core/line_fold_word_wrap.sv
tb/tb_line_fold_word_wrap.sv
